// ===== sv/ffha_pkg.sv =====
// Package for the first-fit heap allocator: beat types, command and status codes,
// register indexes and reset values. No dependencies.
package ffha_pkg;

    localparam int DEF_MAX_BLOCKS  = 64;
    localparam int DEF_OFFSET_BITS = 25;

    localparam int WORD_W    = 32;
    localparam int SIZE_W    = 25;
    localparam int HDR_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_CALLOC  = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_RESIZE  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER     = 2'd2;

    localparam logic [WORD_W-1:0] RST_HEAP_BASE  = 32'd65536;
    localparam logic [SIZE_W-1:0] RST_HEAP_BYTES = 25'd1048576;
    localparam logic [HDR_W-1:0]  RST_HEADER     = 7'd24;

    localparam int ALIGN_BYTES   = 16;
    localparam int MIN_REMAINDER = 32;

    typedef struct packed {
        logic [1:0]        command;
        logic [WORD_W-1:0] request_size;
        logic [WORD_W-1:0] item_count;
        logic [WORD_W-1:0] pointer;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] result_address;
        logic [WORD_W-1:0] move_source;
        logic [SIZE_W-1:0] move_bytes;
        logic [SIZE_W-1:0] clear_bytes;
    } rsp_t;

endpackage

// ===== sv/first_fit_heap_allocator.sv =====
// First-fit heap allocator engine with an address-ordered block table in one memory.
// Depends on ffha_pkg for beat types, codes and reset values.
//
//  channel | signals                               | beat
//  in      | in_valid, in_ready, in_data           | one command (ffha_pkg::cmd_t)
//  out     | out_valid, out_ready, out_data        | one result (ffha_pkg::rsp_t)
//  config  | cfg_write_en, cfg_index, cfg_data     | one register write, no wait
//
// A command is decoded, then walks the block table entry by entry (search, shift, merge pass)
// and then gives its result; a moving resize walks up to five times. The table has a single
// read port, so each walk reads its entries one after another.
// Reset clears the block count and the heap top and loads the registers with their reset values;
// the table needs no clearing. A new command is taken while a result still waits on the output;
// a stalled output holds the engine only when its next result is ready.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS  = ffha_pkg::DEF_MAX_BLOCKS,
    parameter int OFFSET_BITS = ffha_pkg::DEF_OFFSET_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  ffha_pkg::cmd_t                       in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ffha_pkg::rsp_t                       out_data,
    input  logic                                 cfg_write_en,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ffha_pkg::WORD_W-1:0]          cfg_data
);
    import ffha_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [32:0] REGION_CAP = (33'd1 << OFFSET_BITS) - 33'd1;
    localparam logic [33:0] REQ_SAT    = 34'h2_0000_0000;
    localparam logic [33:0] ALIGN_M1   = 34'(ALIGN_BYTES - 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_MUL     = 5'd1;
    localparam logic [4:0] S_DISP    = 5'd2;
    localparam logic [4:0] S_SCAN    = 5'd3;
    localparam logic [4:0] S_LOOKED  = 5'd4;
    localparam logic [4:0] S_GROW    = 5'd5;
    localparam logic [4:0] S_SPLIT   = 5'd6;
    localparam logic [4:0] S_SHUP    = 5'd7;
    localparam logic [4:0] S_SPNEW   = 5'd8;
    localparam logic [4:0] S_SPOLD   = 5'd9;
    localparam logic [4:0] S_SUCC_RD = 5'd10;
    localparam logic [4:0] S_SUCC    = 5'd11;
    localparam logic [4:0] S_SHDN    = 5'd12;
    localparam logic [4:0] S_MARK    = 5'd13;
    localparam logic [4:0] S_MERGE   = 5'd14;
    localparam logic [4:0] S_DONE    = 5'd15;

    localparam logic [1:0] M_FIT = 2'd0;
    localparam logic [1:0] M_PTR = 2'd1;
    localparam logic [1:0] M_OFF = 2'd2;

    logic [WORD_W-1:0] mem_off  [MAX_BLOCKS];
    logic [WORD_W-1:0] mem_size [MAX_BLOCKS];
    logic              mem_free [MAX_BLOCKS];

    logic [WORD_W-1:0] rd_off_reg, rd_size_reg;
    logic              rd_free_reg;
    logic              rd_v_reg;
    logic [IDX_W-1:0]  rd_tag_reg;

    logic              rd_en, wr_en, wr_free;
    logic [IDX_W-1:0]  rd_idx, wr_idx;
    logic [WORD_W-1:0] wr_off, wr_size;

    logic [4:0]        state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [WORD_W-1:0] rs_reg, rs_next, items_reg, items_next, ptr_reg, ptr_next;
    logic [63:0]       prod_reg, prod_next;
    logic [33:0]       req_reg, req_next;
    logic [WORD_W-1:0] tgt_off_reg, tgt_off_next;
    logic [1:0]        mode_reg, mode_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [WORD_W-1:0] hit_off_reg, hit_off_next, hit_size_reg, hit_size_next;
    logic [WORD_W-1:0] old_off_reg, old_off_next, old_size_reg, old_size_next;
    logic              moving_reg, moving_next;
    logic [IDX_W-1:0]  alloc_idx_reg, alloc_idx_next;
    logic              pend_v_reg, pend_v_next, pend_free_reg, pend_free_next;
    logic [WORD_W-1:0] pend_off_reg, pend_off_next, pend_size_reg, pend_size_next;
    logic [CNT_W-1:0]  dst_reg, dst_next;
    logic [CNT_W-1:0]  blk_cnt_reg, blk_cnt_next;
    logic [OFFSET_BITS-1:0] heap_top_reg, heap_top_next;
    logic [WORD_W-1:0] heap_base_reg;
    logic [SIZE_W-1:0] heap_bytes_reg;
    logic [HDR_W-1:0]  hdr_reg;
    rsp_t              work_reg, work_next, out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [WORD_W-1:0] hdr32;
    logic [32:0]       limit;
    logic [63:0]       amount;
    logic [33:0]       req_round;
    logic              match;
    logic [34:0]       split_need;
    logic              do_split;
    logic [34:0]       grow_end;
    logic [33:0]       succ_sum, pend_end, merge_sum;
    logic [CNT_W-1:0]  hit_cnt;

    always_comb
    begin
        hdr32      = WORD_W'(hdr_reg);
        limit      = ({8'd0, heap_bytes_reg} < REGION_CAP) ? {8'd0, heap_bytes_reg}
                                                            : REGION_CAP;
        amount     = (cmd_reg == CMD_CALLOC) ? prod_reg : 64'(rs_reg);
        req_round  = (|amount[63:33]) ? REQ_SAT
                                      : ((34'(amount[32:0]) + ALIGN_M1) & ~ALIGN_M1);
        split_need = 35'(req_reg) + 35'(hdr_reg) + 35'(MIN_REMAINDER);
        do_split   = (35'(hit_size_reg) >= split_need)
                     && (blk_cnt_reg < CNT_W'(MAX_BLOCKS));
        grow_end   = 35'(heap_top_reg) + 35'(hdr_reg) + 35'(req_reg);
        succ_sum   = 34'(hit_size_reg) + 34'(hdr_reg) + 34'(rd_size_reg);
        pend_end   = 34'(pend_off_reg) + 34'(hdr_reg) + 34'(pend_size_reg);
        merge_sum  = 34'(pend_size_reg) + 34'(hdr_reg) + 34'(rd_size_reg);
        hit_cnt    = CNT_W'(hit_idx_reg);
        unique case (mode_reg)
            M_FIT:   match = rd_free_reg && (34'(rd_size_reg) >= req_reg);
            M_PTR:   match = !rd_free_reg && (rd_off_reg == tgt_off_reg);
            M_OFF:   match = !rd_free_reg && (rd_off_reg == old_off_reg)
                             && (rd_tag_reg != alloc_idx_reg);
            default: match = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        rs_next        = rs_reg;
        items_next     = items_reg;
        ptr_next       = ptr_reg;
        prod_next      = prod_reg;
        req_next       = req_reg;
        tgt_off_next   = tgt_off_reg;
        mode_next      = mode_reg;
        iss_next       = iss_reg;
        hit_idx_next   = hit_idx_reg;
        hit_off_next   = hit_off_reg;
        hit_size_next  = hit_size_reg;
        old_off_next   = old_off_reg;
        old_size_next  = old_size_reg;
        moving_next    = moving_reg;
        alloc_idx_next = alloc_idx_reg;
        pend_v_next    = pend_v_reg;
        pend_free_next = pend_free_reg;
        pend_off_next  = pend_off_reg;
        pend_size_next = pend_size_reg;
        dst_next       = dst_reg;
        blk_cnt_next   = blk_cnt_reg;
        heap_top_next  = heap_top_reg;
        work_next      = work_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        rd_en          = 1'b0;
        rd_idx         = iss_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_idx         = hit_idx_reg;
        wr_off         = hit_off_reg;
        wr_size        = hit_size_reg;
        wr_free        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next    = in_data.command;
                    rs_next     = in_data.request_size;
                    items_next  = in_data.item_count;
                    ptr_next    = in_data.pointer;
                    work_next   = '0;
                    moving_next = 1'b0;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next    = 64'(rs_reg) * 64'(items_reg);
                tgt_off_next = ptr_reg - heap_base_reg - hdr32;
                state_next   = S_DISP;
            end
            S_DISP:
            begin
                req_next = req_round;
                iss_next = '0;
                if (cmd_reg == CMD_ALLOC || cmd_reg == CMD_CALLOC
                    || (cmd_reg == CMD_RESIZE && ptr_reg == '0))
                begin
                    if (amount == 64'd0)
                    begin
                        work_next.status = ST_NULL;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        mode_next  = M_FIT;
                        state_next = S_SCAN;
                    end
                end
                else if (ptr_reg == '0)
                begin
                    work_next.status = ST_NULL;
                    state_next       = S_DONE;
                end
                else
                begin
                    mode_next  = M_PTR;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_en = iss_reg < blk_cnt_reg;
                if (rd_en)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (rd_v_reg && match)
                begin
                    hit_idx_next  = rd_tag_reg;
                    hit_off_next  = rd_off_reg;
                    hit_size_next = rd_size_reg;
                    unique case (mode_reg)
                        M_FIT:
                        begin
                            work_next.result_address = heap_base_reg + rd_off_reg + hdr32;
                            alloc_idx_next = rd_tag_reg;
                            state_next     = S_SPLIT;
                        end
                        M_PTR:   state_next = S_LOOKED;
                        default: state_next = S_MARK;
                    endcase
                end
                else if (!rd_v_reg && iss_reg == blk_cnt_reg)
                begin
                    unique case (mode_reg)
                        M_FIT:   state_next = S_GROW;
                        M_PTR:
                        begin
                            work_next.status = ST_UNKNOWN;
                            state_next       = S_DONE;
                        end
                        default:
                        begin
                            iss_next    = '0;
                            dst_next    = '0;
                            pend_v_next = 1'b0;
                            state_next  = S_MERGE;
                        end
                    endcase
                end
            end
            S_LOOKED:
            begin
                iss_next = '0;
                if (cmd_reg == CMD_RELEASE)
                begin
                    state_next = S_MARK;
                end
                else if (rs_reg == '0)
                begin
                    work_next.status = ST_NULL;
                    state_next       = S_MARK;
                end
                else if (req_reg <= 34'(hit_size_reg))
                begin
                    work_next.result_address = ptr_reg;
                    state_next = S_SPLIT;
                end
                else if (hit_cnt + CNT_W'(1) < blk_cnt_reg)
                begin
                    state_next = S_SUCC_RD;
                end
                else
                begin
                    old_off_next  = hit_off_reg;
                    old_size_next = hit_size_reg;
                    moving_next   = 1'b1;
                    mode_next     = M_FIT;
                    state_next    = S_SCAN;
                end
            end
            S_SUCC_RD:
            begin
                rd_en      = 1'b1;
                rd_idx     = hit_idx_reg + IDX_W'(1);
                state_next = S_SUCC;
            end
            S_SUCC:
            begin
                if (rd_free_reg && succ_sum >= req_reg)
                begin
                    hit_size_next            = succ_sum[WORD_W-1:0];
                    work_next.result_address = ptr_reg;
                    iss_next                 = hit_cnt + CNT_W'(2);
                    state_next               = S_SHDN;
                end
                else
                begin
                    old_off_next  = hit_off_reg;
                    old_size_next = hit_size_reg;
                    moving_next   = 1'b1;
                    iss_next      = '0;
                    mode_next     = M_FIT;
                    state_next    = S_SCAN;
                end
            end
            S_SHDN:
            begin
                rd_en = iss_reg < blk_cnt_reg;
                if (rd_en)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (rd_v_reg)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = rd_tag_reg - IDX_W'(1);
                    wr_off  = rd_off_reg;
                    wr_size = rd_size_reg;
                    wr_free = rd_free_reg;
                end
                else if (iss_reg >= blk_cnt_reg)
                begin
                    blk_cnt_next = blk_cnt_reg - CNT_W'(1);
                    state_next   = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (!do_split)
                begin
                    wr_en = 1'b1;
                    if (moving_reg)
                    begin
                        iss_next   = '0;
                        mode_next  = M_OFF;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (hit_cnt + CNT_W'(1) < blk_cnt_reg)
                begin
                    iss_next   = blk_cnt_reg - CNT_W'(1);
                    state_next = S_SHUP;
                end
                else
                begin
                    state_next = S_SPNEW;
                end
            end
            S_SHUP:
            begin
                rd_en = iss_reg > hit_cnt;
                if (rd_en)
                begin
                    iss_next = iss_reg - CNT_W'(1);
                end
                if (rd_v_reg)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = rd_tag_reg + IDX_W'(1);
                    wr_off  = rd_off_reg;
                    wr_size = rd_size_reg;
                    wr_free = rd_free_reg;
                end
                else if (!rd_en)
                begin
                    state_next = S_SPNEW;
                end
            end
            S_SPNEW:
            begin
                wr_en      = 1'b1;
                wr_idx     = hit_idx_reg + IDX_W'(1);
                wr_off     = hit_off_reg + hdr32 + req_reg[WORD_W-1:0];
                wr_size    = hit_size_reg - req_reg[WORD_W-1:0] - hdr32;
                wr_free    = 1'b1;
                state_next = S_SPOLD;
            end
            S_SPOLD:
            begin
                wr_en        = 1'b1;
                wr_size      = req_reg[WORD_W-1:0];
                blk_cnt_next = blk_cnt_reg + CNT_W'(1);
                if (moving_reg)
                begin
                    iss_next   = '0;
                    mode_next  = M_OFF;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_GROW:
            begin
                if (grow_end > 35'(limit) || blk_cnt_reg >= CNT_W'(MAX_BLOCKS))
                begin
                    work_next.status = ST_NOMEM;
                    state_next       = S_DONE;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_idx         = blk_cnt_reg[IDX_W-1:0];
                    wr_off         = WORD_W'(heap_top_reg);
                    wr_size        = req_reg[WORD_W-1:0];
                    alloc_idx_next = blk_cnt_reg[IDX_W-1:0];
                    work_next.result_address = heap_base_reg + WORD_W'(heap_top_reg) + hdr32;
                    heap_top_next  = grow_end[OFFSET_BITS-1:0];
                    blk_cnt_next   = blk_cnt_reg + CNT_W'(1);
                    if (moving_reg)
                    begin
                        iss_next   = '0;
                        mode_next  = M_OFF;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MARK:
            begin
                wr_en       = 1'b1;
                wr_free     = 1'b1;
                iss_next    = '0;
                dst_next    = '0;
                pend_v_next = 1'b0;
                state_next  = S_MERGE;
            end
            S_MERGE:
            begin
                rd_en = iss_reg < blk_cnt_reg;
                if (rd_en)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                wr_idx  = dst_reg[IDX_W-1:0];
                wr_off  = pend_off_reg;
                wr_size = pend_size_reg;
                wr_free = pend_free_reg;
                if (rd_v_reg)
                begin
                    if (!pend_v_reg)
                    begin
                        pend_v_next = 1'b1;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        dst_next = dst_reg + CNT_W'(1);
                        if (pend_free_reg && rd_free_reg && pend_end == 34'(rd_off_reg))
                        begin
                            wr_size     = merge_sum[WORD_W-1:0];
                            pend_v_next = 1'b0;
                        end
                    end
                    pend_off_next  = rd_off_reg;
                    pend_size_next = rd_size_reg;
                    pend_free_next = rd_free_reg;
                end
                else if (!rd_en)
                begin
                    wr_en        = pend_v_reg;
                    blk_cnt_next = dst_reg + CNT_W'(pend_v_reg);
                    pend_v_next  = 1'b0;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next = work_reg;
                    if (moving_reg && work_reg.status == ST_OK)
                    begin
                        out_next.move_source = ptr_reg;
                        out_next.move_bytes  = old_size_reg[SIZE_W-1:0];
                    end
                    if (cmd_reg == CMD_CALLOC && work_reg.status == ST_OK)
                    begin
                        out_next.clear_bytes = prod_reg[SIZE_W-1:0];
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_off[wr_idx]  <= wr_off;
            mem_size[wr_idx] <= wr_size;
            mem_free[wr_idx] <= wr_free;
        end
        if (rd_en)
        begin
            rd_off_reg  <= mem_off[rd_idx];
            rd_size_reg <= mem_size[rd_idx];
            rd_free_reg <= mem_free[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= RST_HEAP_BASE;
            heap_bytes_reg <= RST_HEAP_BYTES;
            hdr_reg        <= RST_HEADER;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                REG_HEAP_BYTES: heap_bytes_reg <= cfg_data[SIZE_W-1:0];
                REG_HEADER:     hdr_reg        <= cfg_data[HDR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            rs_reg        <= '0;
            items_reg     <= '0;
            ptr_reg       <= '0;
            prod_reg      <= '0;
            req_reg       <= '0;
            tgt_off_reg   <= '0;
            mode_reg      <= M_FIT;
            iss_reg       <= '0;
            hit_idx_reg   <= '0;
            hit_off_reg   <= '0;
            hit_size_reg  <= '0;
            old_off_reg   <= '0;
            old_size_reg  <= '0;
            moving_reg    <= 1'b0;
            alloc_idx_reg <= '0;
            pend_v_reg    <= 1'b0;
            pend_free_reg <= 1'b0;
            pend_off_reg  <= '0;
            pend_size_reg <= '0;
            dst_reg       <= '0;
            blk_cnt_reg   <= '0;
            heap_top_reg  <= '0;
            work_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
            rd_tag_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            rs_reg        <= rs_next;
            items_reg     <= items_next;
            ptr_reg       <= ptr_next;
            prod_reg      <= prod_next;
            req_reg       <= req_next;
            tgt_off_reg   <= tgt_off_next;
            mode_reg      <= mode_next;
            iss_reg       <= iss_next;
            hit_idx_reg   <= hit_idx_next;
            hit_off_reg   <= hit_off_next;
            hit_size_reg  <= hit_size_next;
            old_off_reg   <= old_off_next;
            old_size_reg  <= old_size_next;
            moving_reg    <= moving_next;
            alloc_idx_reg <= alloc_idx_next;
            pend_v_reg    <= pend_v_next;
            pend_free_reg <= pend_free_next;
            pend_off_reg  <= pend_off_next;
            pend_size_reg <= pend_size_next;
            dst_reg       <= dst_next;
            blk_cnt_reg   <= blk_cnt_next;
            heap_top_reg  <= heap_top_next;
            work_reg      <= work_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            rd_v_reg      <= rd_en;
            rd_tag_reg    <= rd_idx;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The table never holds more blocks than it has entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        blk_cnt_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond table depth");

    // Any result other than success hands back a null address.
    a_null_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == ST_OK || out_reg.result_address == '0))
        else $error("failed result carries an address");

    // The table is left alone while the engine waits for a command.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("table write while idle");

    // The heap top only grows.
    a_top_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> heap_top_reg >= $past(heap_top_reg))
        else $error("heap top moved down");

endmodule
